// ===== sv/opn_pkg.sv =====
// ----------------------------------------------------------------------------
// opn_pkg
// Types, constants and codes shared by the orthogonal polynomial Newton step.
// ----------------------------------------------------------------------------
`default_nettype none

package opn_pkg;

  // number format and limits
  localparam int FRAC_BITS  = 30;
  localparam int MAX_DEGREE = 64;

  localparam int DEG_W    = 7;
  localparam int TOL_W    = 10;
  localparam int X_W      = 32;
  localparam int DER_W    = 44;
  localparam int W_W      = 33;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0]        LIM62  = 64'd1 << 62;
  localparam logic [63:0]        PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0]        PI_Q   =
    (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);

  localparam logic signed [63:0] DER_MAX = (64'sd1 <<< (DER_W - 1)) - 64'sd1;
  localparam logic signed [63:0] DER_MIN = -(64'sd1 <<< (DER_W - 1));
  localparam logic signed [63:0] NX_MAX  = (64'sd1 <<< (X_W - 1)) - 64'sd1;
  localparam logic signed [63:0] NX_MIN  = -(64'sd1 <<< (X_W - 1));
  localparam logic signed [63:0] W_MAX   = (64'sd1 <<< W_W) - 64'sd1;

  // dividend widths for the bit-serial quotient loop
  localparam logic [6:0] NB_REC  = 7'(FRAC_BITS + 10);
  localparam logic [6:0] NB_DER  = 7'(2 * FRAC_BITS + 8);
  localparam logic [6:0] NB_STEP = 7'(2 * FRAC_BITS + 2);
  localparam logic [6:0] NB_WL   = 7'(2 * FRAC_BITS + 2);
  localparam logic [6:0] NB_WC   = 7'(FRAC_BITS + 4);
  localparam int         Q_W     = 2 * FRAC_BITS + 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE = 2'd0,
    CFG_FAMILY = 2'd1,
    CFG_TOL    = 2'd2
  } cfg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // shared unit operations
  typedef enum logic [1:0] {
    MD_RAW   = 2'd0,
    MD_SHIFT = 2'd1,
    MD_DIV   = 2'd2,
    MD_TRUNC = 2'd3
  } md_mode_e;

  typedef struct packed {
    md_mode_e           mode;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [62:0]        c;
    logic [6:0]         nbits;
  } md_req_t;

  typedef struct packed {
    logic signed [63:0] res;
    logic               sat;
  } md_rsp_t;

  typedef struct packed {
    logic signed [X_W-1:0]   poly_value;
    logic signed [DER_W-1:0] derivative;
    logic signed [X_W-1:0]   next_x;
    logic                    converged;
    logic [W_W-1:0]          weight;
    status_e                 status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/opn_in_if.sv =====
// ----------------------------------------------------------------------------
// opn_in_if
// Input channel: one evaluation point per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface opn_in_if import opn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x;

  modport source (output valid, output x, input ready);
  modport sink   (input valid, input x, output ready);
endinterface

`default_nettype wire

// ===== sv/opn_out_if.sv =====
// ----------------------------------------------------------------------------
// opn_out_if
// Output channel: one Newton step result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface opn_out_if import opn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [X_W-1:0]   poly_value;
  logic signed [DER_W-1:0] derivative;
  logic signed [X_W-1:0]   next_x;
  logic                    converged;
  logic [W_W-1:0]          weight;
  logic [1:0]              status;

  modport source (output valid, output poly_value, output derivative, output next_x,
                  output converged, output weight, output status, input ready);
  modport sink   (input valid, input poly_value, input derivative, input next_x,
                  input converged, input weight, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/opn_muldiv.sv =====
// ----------------------------------------------------------------------------
// opn_muldiv
// Shared multiply / divide unit: a*b, a*b >> FRAC_BITS or round/trunc(a*b/c)
// with four 32x32 partial products; quotient: restoring, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module opn_muldiv import opn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  md_req_t req_i,
  output logic    done_o,
  output md_rsp_t rsp_o
);

  typedef enum logic [5:0] {
    MD_IDLE = 6'b000001,
    MD_MUL  = 6'b000010,
    MD_LOAD = 6'b000100,
    MD_QUO  = 6'b001000,
    MD_FIN  = 6'b010000,
    MD_DONE = 6'b100000
  } md_state_e;

  md_state_e       state_q, state_d;
  md_mode_e        mode_q, mode_d;
  logic            neg_q, neg_d;
  logic [63:0]     ua_q, ua_d, ub_q, ub_d;
  logic [62:0]     c_q, c_d;
  logic [6:0]      nb_q, nb_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [127:0]    acc_q, acc_d;
  logic [62:0]     rem_q, rem_d;
  logic [Q_W-1:0]  quo_q, quo_d;
  md_rsp_t         rsp_q, rsp_d;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [1:0]   sh_sel;
  logic [127:0] pp_sh;
  logic [63:0]  rs, rdiff;
  logic         ge;
  logic         rnd_div;
  logic [128:0] big;
  logic         sat;
  logic [63:0]  mag;
  logic [7:0]   load_sh;

  // partial product select
  assign a_half = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
  assign b_half = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
  assign pp     = a_half * b_half;
  assign sh_sel = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};

  always_comb begin
    case (sh_sel)
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  // restoring quotient step
  assign rs    = {rem_q, acc_q[127]};
  assign ge    = rs >= {1'b0, c_q};
  assign rdiff = rs - {1'b0, c_q};

  // final rounding and saturation
  assign rnd_div = rem_q >= (c_q - rem_q);
  assign load_sh = 8'd128 - {1'b0, nb_q};

  always_comb begin
    case (mode_q)
      MD_SHIFT: big = {1'b0, acc_q >> FRAC_BITS} + 129'(acc_q[FRAC_BITS-1]);
      MD_DIV:   big = 129'(quo_q) + 129'(rnd_div);
      MD_TRUNC: big = 129'(quo_q);
      default:  big = 129'(acc_q[63:0]);
    endcase
  end

  assign sat = (mode_q != MD_RAW) && (big > 129'(LIM62));
  assign mag = sat ? LIM62 : big[63:0];

  // sequencing
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    neg_d   = neg_q;
    ua_d    = ua_q;
    ub_d    = ub_q;
    c_d     = c_q;
    nb_d    = nb_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    rsp_d   = rsp_q;
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          mode_d  = req_i.mode;
          neg_d   = req_i.a[63] ^ req_i.b[63];
          ua_d    = req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
          ub_d    = req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
          c_d     = req_i.c;
          nb_d    = req_i.nbits;
          cnt_d   = 7'd0;
          acc_d   = 128'd0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          if (mode_q == MD_DIV || mode_q == MD_TRUNC) begin
            state_d = MD_LOAD;
          end else begin
            state_d = MD_FIN;
          end
        end
      end
      MD_LOAD: begin
        acc_d   = acc_q << load_sh;
        rem_d   = 63'd0;
        quo_d   = '0;
        cnt_d   = nb_q;
        state_d = MD_QUO;
      end
      MD_QUO: begin
        rem_d = ge ? rdiff[62:0] : rs[62:0];
        quo_d = {quo_q[Q_W-2:0], ge};
        acc_d = acc_q << 1;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = MD_FIN;
        end
      end
      MD_FIN: begin
        rsp_d.res = neg_q ? -$signed(mag) : $signed(mag);
        rsp_d.sat = sat;
        state_d   = MD_DONE;
      end
      MD_DONE: begin
        state_d = MD_IDLE;
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    neg_q  <= neg_d;
    ua_q   <= ua_d;
    ub_q   <= ub_d;
    c_q    <= c_d;
    nb_q   <= nb_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = (state_q == MD_DONE);
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== sv/opn_seq.sv =====
// ----------------------------------------------------------------------------
// opn_seq
// Sequencer: runs the three-term recurrence, derivative, Newton step and
// weight as a chain of operations on the shared multiply / divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

module opn_seq import opn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [X_W-1:0] x_i,
  input  logic [DEG_W-1:0]      degree_i,
  input  logic                  family_i,
  input  logic [TOL_W-1:0]      tol_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output out_item_t             res_o
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_T    = 15'b000000000000010,
    S_A    = 15'b000000000000100,
    S_B    = 15'b000000000001000,
    S_V    = 15'b000000000010000,
    S_D    = 15'b000000000100000,
    S_XP   = 15'b000000001000000,
    S_NUM  = 15'b000000010000000,
    S_DER  = 15'b000000100000000,
    S_STEP = 15'b000001000000000,
    S_D2   = 15'b000010000000000,
    S_DEN  = 15'b000100000000000,
    S_W    = 15'b001000000000000,
    S_FIN  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } seq_state_e;

  seq_state_e            state_q, state_d;
  logic                  issued_q, issued_d;
  logic signed [X_W-1:0] x_q, x_d, p_q, p_d, pm1_q, pm1_d, t_q, t_d;
  logic [DEG_W-1:0]      n_q, n_d, k_q, k_d;
  logic                  fam_q, fam_d;
  logic [TOL_W-1:0]      tol_q, tol_d;
  logic [31:0]           d_q, d_d;
  logic signed [63:0]    a_q, a_d, der_q, der_d, step_q, step_d, w_q, w_d;
  logic                  sat_q, sat_d, divz_q, divz_d;
  out_item_t             res_q, res_d;

  md_req_t               md_req;
  md_rsp_t               md_rsp;
  logic                  md_start, md_done;
  logic                  op_state;

  logic signed [X_W-1:0] x_clamp;
  logic [DEG_W-1:0]      n_clamp;
  logic signed [63:0]    der_abs;
  logic signed [X_W-1:0] nxt;
  logic                  adv;
  logic signed [63:0]    nx_diff, step_abs;
  logic                  der_clip, nx_clip, w_clip;

  function automatic logic signed [X_W-1:0] clamp_unit(input logic signed [63:0] v);
    logic signed [X_W-1:0] r;
    if (v > ONE_Q) begin
      r = X_W'(ONE_Q);
    end else if (v < -ONE_Q) begin
      r = X_W'(-ONE_Q);
    end else begin
      r = v[X_W-1:0];
    end
    return r;
  endfunction

  opn_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .req_i   (md_req),
    .done_o  (md_done),
    .rsp_o   (md_rsp)
  );

  // input conditioning
  assign x_clamp = clamp_unit(64'(x_i));
  always_comb begin
    if (degree_i == '0) begin
      n_clamp = DEG_W'(1);
    end else if (degree_i > DEG_W'(MAX_DEGREE)) begin
      n_clamp = DEG_W'(MAX_DEGREE);
    end else begin
      n_clamp = degree_i;
    end
  end

  assign der_abs = der_q[63] ? -der_q : der_q;

  // operation issued in each state
  always_comb begin
    md_req.mode  = MD_RAW;
    md_req.a     = 64'sd0;
    md_req.b     = 64'sd0;
    md_req.c     = 63'd1;
    md_req.nbits = 7'd1;
    case (state_q)
      S_T: begin
        md_req.mode = MD_SHIFT;
        md_req.a    = 64'(x_q);
        md_req.b    = 64'(p_q);
      end
      S_A: begin
        md_req.a = {56'd0, k_q, 1'b1};
        md_req.b = 64'(t_q);
      end
      S_B: begin
        md_req.a = {57'd0, k_q};
        md_req.b = 64'(pm1_q);
      end
      S_V: begin
        md_req.mode  = MD_DIV;
        md_req.a     = a_q;
        md_req.b     = 64'sd1;
        md_req.c     = 63'(k_q) + 63'd1;
        md_req.nbits = NB_REC;
      end
      S_D: begin
        md_req.mode = MD_SHIFT;
        md_req.a    = 64'(x_q);
        md_req.b    = 64'(x_q);
      end
      S_XP: begin
        md_req.mode = MD_SHIFT;
        md_req.a    = 64'(x_q);
        md_req.b    = 64'(p_q);
      end
      S_NUM: begin
        md_req.a = {57'd0, n_q};
        md_req.b = a_q;
      end
      S_DER: begin
        md_req.mode  = MD_DIV;
        md_req.a     = a_q;
        md_req.b     = ONE_Q;
        md_req.c     = 63'(d_q);
        md_req.nbits = NB_DER;
      end
      S_STEP: begin
        md_req.mode  = MD_DIV;
        md_req.a     = 64'(p_q);
        md_req.b     = ONE_Q;
        md_req.c     = der_abs[62:0];
        md_req.nbits = NB_STEP;
      end
      S_D2: begin
        md_req.mode = MD_SHIFT;
        md_req.a    = der_q;
        md_req.b    = der_q;
      end
      S_DEN: begin
        md_req.mode = MD_SHIFT;
        md_req.a    = a_q;
        md_req.b    = {32'd0, d_q};
      end
      S_W: begin
        if (fam_q) begin
          md_req.mode  = MD_TRUNC;
          md_req.a     = $signed(PI_Q + 64'(n_q >> 1));
          md_req.b     = 64'sd1;
          md_req.c     = 63'(n_q);
          md_req.nbits = NB_WC;
        end else begin
          md_req.mode  = MD_DIV;
          md_req.a     = ONE_Q <<< 1;
          md_req.b     = ONE_Q;
          md_req.c     = a_q[62:0];
          md_req.nbits = NB_WL;
        end
      end
      default: begin
        md_req.mode = MD_RAW;
      end
    endcase
  end

  assign op_state = (state_q != S_IDLE) && (state_q != S_FIN) && (state_q != S_OUT);
  assign md_start = op_state && !issued_q;

  // next recurrence value
  always_comb begin
    if (state_q == S_T) begin
      nxt = clamp_unit((md_rsp.res <<< 1) - 64'(pm1_q));
    end else begin
      nxt = clamp_unit(md_rsp.res);
    end
  end
  assign adv = md_done && ((state_q == S_T && fam_q) || state_q == S_V);

  // result shaping
  assign nx_diff  = 64'(x_q) - step_q;
  assign step_abs = step_q[63] ? -step_q : step_q;
  assign der_clip = (der_q > DER_MAX) || (der_q < DER_MIN);
  assign nx_clip  = (nx_diff > NX_MAX) || (nx_diff < NX_MIN);
  assign w_clip   = (w_q > W_MAX);

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    x_d      = x_q;
    p_d      = p_q;
    pm1_d    = pm1_q;
    t_d      = t_q;
    n_d      = n_q;
    k_d      = k_q;
    fam_d    = fam_q;
    tol_d    = tol_q;
    d_d      = d_q;
    a_d      = a_q;
    der_d    = der_q;
    step_d   = step_q;
    w_d      = w_q;
    sat_d    = sat_q;
    divz_d   = divz_q;
    res_d    = res_q;

    if (md_start) begin
      issued_d = 1'b1;
    end
    if (md_done) begin
      issued_d = 1'b0;
    end

    // recurrence advance
    if (adv) begin
      pm1_d   = p_q;
      p_d     = nxt;
      k_d     = k_q + DEG_W'(1);
      state_d = ((k_q + DEG_W'(1)) < n_q) ? S_T : S_D;
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d     = x_clamp;
          p_d     = x_clamp;
          pm1_d   = X_W'(ONE_Q);
          n_d     = n_clamp;
          k_d     = DEG_W'(1);
          fam_d   = family_i;
          tol_d   = tol_i;
          der_d   = 64'sd0;
          step_d  = 64'sd0;
          w_d     = 64'sd0;
          sat_d   = 1'b0;
          divz_d  = 1'b0;
          state_d = (n_clamp > DEG_W'(1)) ? S_T : S_D;
        end
      end
      S_T: begin
        if (md_done) begin
          t_d = md_rsp.res[X_W-1:0];
          if (!fam_q) begin
            state_d = S_A;
          end
        end
      end
      S_A: begin
        if (md_done) begin
          a_d     = md_rsp.res;
          state_d = S_B;
        end
      end
      S_B: begin
        if (md_done) begin
          a_d     = a_q - md_rsp.res;
          state_d = S_V;
        end
      end
      S_D: begin
        if (md_done) begin
          if (md_rsp.res >= ONE_Q) begin
            divz_d  = 1'b1;
            state_d = S_FIN;
          end else begin
            d_d     = 32'(ONE_Q - md_rsp.res);
            state_d = S_XP;
          end
        end
      end
      S_XP: begin
        if (md_done) begin
          a_d     = 64'(pm1_q) - md_rsp.res;
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        if (md_done) begin
          a_d     = md_rsp.res;
          state_d = S_DER;
        end
      end
      S_DER: begin
        if (md_done) begin
          der_d = md_rsp.res;
          sat_d = sat_q | md_rsp.sat;
          if (md_rsp.res == 64'sd0) begin
            divz_d  = 1'b1;
            state_d = S_FIN;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (md_done) begin
          step_d  = der_q[63] ? -md_rsp.res : md_rsp.res;
          sat_d   = sat_q | md_rsp.sat;
          state_d = fam_q ? S_W : S_D2;
        end
      end
      S_D2: begin
        if (md_done) begin
          a_d     = md_rsp.res;
          sat_d   = sat_q | md_rsp.sat;
          state_d = S_DEN;
        end
      end
      S_DEN: begin
        if (md_done) begin
          a_d   = md_rsp.res;
          sat_d = sat_q | md_rsp.sat;
          if (md_rsp.res <= 64'sd0) begin
            w_d     = W_MAX;
            sat_d   = 1'b1;
            state_d = S_FIN;
          end else begin
            state_d = S_W;
          end
        end
      end
      S_W: begin
        if (md_done) begin
          w_d     = md_rsp.res;
          sat_d   = sat_q | md_rsp.sat;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_d.poly_value = p_q;
        if (der_q > DER_MAX) begin
          res_d.derivative = DER_MAX[DER_W-1:0];
        end else if (der_q < DER_MIN) begin
          res_d.derivative = DER_MIN[DER_W-1:0];
        end else begin
          res_d.derivative = der_q[DER_W-1:0];
        end
        if (divz_q) begin
          res_d.next_x    = x_q;
          res_d.converged = 1'b0;
          res_d.weight    = '0;
          res_d.status    = ST_DIVZ;
        end else begin
          if (nx_diff > NX_MAX) begin
            res_d.next_x = NX_MAX[X_W-1:0];
          end else if (nx_diff < NX_MIN) begin
            res_d.next_x = NX_MIN[X_W-1:0];
          end else begin
            res_d.next_x = nx_diff[X_W-1:0];
          end
          res_d.converged = step_abs <= 64'(tol_q);
          res_d.weight    = w_clip ? W_MAX[W_W-1:0] : w_q[W_W-1:0];
          res_d.status    = (sat_q || der_clip || nx_clip || w_clip) ? ST_SAT : ST_OK;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        if (!adv) begin
          state_d = state_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    p_q    <= p_d;
    pm1_q  <= pm1_d;
    t_q    <= t_d;
    n_q    <= n_d;
    k_q    <= k_d;
    fam_q  <= fam_d;
    tol_q  <= tol_d;
    d_q    <= d_d;
    a_q    <= a_d;
    der_q  <= der_d;
    step_q <= step_d;
    w_q    <= w_d;
    sat_q  <= sat_d;
    divz_q <= divz_d;
    res_q  <= res_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== sv/orthogonal_poly_newton_step_unit.sv =====
// ----------------------------------------------------------------------------
// orthogonal_poly_newton_step_unit
// One Newton step toward a root of a Legendre or Chebyshev polynomial, with
// derivative, convergence flag and quadrature weight.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one point x (signed Q1.30) per transaction; out_o returns
//   P_n(x), P_n'(x), the updated x, the convergence flag, the weight and a
//   status code. degree, family and tolerance_lsb are set through the write
//   port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the user writes them only while idle,
//   the block itself does not enforce it. One item at a time; in_i.ready is
//   high only while the sequencer is free. All operations share one
//   multiply/divide unit. A finished result moves into the output register,
//   so the next point is taken while the receiver stalls; the sequencer waits
//   only while that register is still full. Reset clears all control state
//   and sets degree 4, family Legendre and tolerance 5.
// ----------------------------------------------------------------------------
`default_nettype none

module orthogonal_poly_newton_step_unit import opn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  opn_in_if.sink               in_i,
  opn_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [DEG_W-1:0] degree_q;
  logic             family_q;
  logic [TOL_W-1:0] tol_q;

  logic      seq_idle, seq_valid, seq_ready;
  out_item_t seq_res;
  logic      out_valid_q;
  out_item_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEG_W'(4);
      family_q <= 1'b0;
      tol_q    <= TOL_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEGREE: degree_q <= cfg_wdata_i[DEG_W-1:0];
        CFG_FAMILY: family_q <= cfg_wdata_i[0];
        CFG_TOL:    tol_q    <= cfg_wdata_i[TOL_W-1:0];
        default:    degree_q <= degree_q;
      endcase
    end
  end

  opn_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_i.valid && in_i.ready),
    .x_i         (in_i.x),
    .degree_i    (degree_q),
    .family_i    (family_q),
    .tol_i       (tol_q),
    .idle_o      (seq_idle),
    .res_valid_o (seq_valid),
    .res_ready_i (seq_ready),
    .res_o       (seq_res)
  );

  assign in_i.ready = seq_idle;

  // output register
  assign seq_ready = seq_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ready) begin
      out_q <= seq_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.poly_value = out_q.poly_value;
  assign out_o.derivative = out_q.derivative;
  assign out_o.next_x     = out_q.next_x;
  assign out_o.converged  = out_q.converged;
  assign out_o.weight     = out_q.weight;
  assign out_o.status     = out_q.status;

endmodule

`default_nettype wire
